@@ sv/psh_pkg.sv @@
// shared types, constants and helpers for the path signature hash unit
package psh_pkg;

  localparam int NodeLimitDefault = 64;
  localparam int StepWidth        = 20;
  localparam int KindWidth        = 4;
  localparam int CountWidth       = 7;
  localparam int LenWidth         = 40;
  localparam int CoordWidth       = 40;
  localparam int IdWidth          = 32;
  localparam int HashWidth        = 64;
  localparam int QueueDepth       = 2;

  localparam logic [HashWidth-1:0] GoldenInc = 64'h9e3779b97f4a7c15;
  localparam logic [StepWidth-1:0] StepReset = 20'd1000;
  localparam logic [KindWidth-1:0] KindReset = 4'd2;

  // opcodes of an input request
  typedef enum logic [1:0] {
    OP_HDR_NLOS = 2'd0,
    OP_HDR_LOS  = 2'd1,
    OP_NODE     = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_STEP = 1'b0,
    REG_KIND = 1'b1
  } reg_idx_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MIX,
    ST_EMIT
  } back_state_t;

  // classified work handed from front to back
  typedef struct packed {
    logic                         is_header;
    logic                         emit;
    logic                         with_media;
    logic [HashWidth-1:0]         v0;   // kind or opcode
    logic [HashWidth-1:0]         v1;   // face or count
    logic [HashWidth-1:0]         v2;   // wedge or biased length in 8 um units
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] z;
    logic [HashWidth-1:0]         v6;   // object
    logic [HashWidth-1:0]         v7;   // medium in
    logic [HashWidth-1:0]         v8;   // medium out
  } work_t;

  function automatic logic [HashWidth-1:0] mix(input logic [HashWidth-1:0] h,
                                               input logic [HashWidth-1:0] v);
    mix = h ^ (v + GoldenInc + (h << 6) + (h >> 2));
  endfunction

  function automatic logic [HashWidth-1:0] sext_id(input logic [IdWidth-1:0] v);
    sext_id = {{(HashWidth-IdWidth){v[IdWidth-1]}}, v};
  endfunction

endpackage

@@ sv/psh_front.sv @@
// front end: accepts requests, tracks the open path and classifies work
module psh_front #(
  parameter int NODE_LIMIT = psh_pkg::NodeLimitDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            opcode,
  input  logic [psh_pkg::CountWidth-1:0]        node_count,
  input  logic [psh_pkg::LenWidth-1:0]          path_length_um,
  input  logic [psh_pkg::KindWidth-1:0]         interaction_kind,
  input  logic [psh_pkg::IdWidth-1:0]           face_index,
  input  logic [psh_pkg::IdWidth-1:0]           wedge_index,
  input  logic [psh_pkg::CoordWidth-1:0]        point_x_um,
  input  logic [psh_pkg::CoordWidth-1:0]        point_y_um,
  input  logic [psh_pkg::CoordWidth-1:0]        point_z_um,
  input  logic [psh_pkg::IdWidth-1:0]           object_index,
  input  logic [psh_pkg::IdWidth-1:0]           medium_in_index,
  input  logic [psh_pkg::IdWidth-1:0]           medium_out_index,
  input  logic [psh_pkg::KindWidth-1:0]         transmission_kind,
  output logic                                  q_push,
  input  logic                                  q_full,
  output psh_pkg::work_t                        q_data
);

  localparam logic [7:0] LimitW = 8'(NODE_LIMIT);

  logic                              path_open;
  logic [psh_pkg::CountWidth-1:0]    nodes_left;
  logic [psh_pkg::CountWidth-1:0]    count_clip;
  logic                              is_hdr;
  logic                              is_node;
  logic [psh_pkg::LenWidth:0]        len_num;

  assign in_ready = !q_full;
  assign is_hdr   = opcode == psh_pkg::OP_HDR_NLOS || opcode == psh_pkg::OP_HDR_LOS;
  assign is_node  = opcode == psh_pkg::OP_NODE && path_open;

  // clip the node count to the limit
  always_comb begin
    if ({1'b0, node_count} > LimitW) count_clip = LimitW[psh_pkg::CountWidth-1:0];
    else count_clip = node_count;
  end

  // length plus half of 1000 um, in 8 um units; the back end divides by 125
  assign len_num = {1'b0, path_length_um} + (psh_pkg::LenWidth+1)'(500);

  // classified request
  always_comb begin
    q_data            = '0;
    q_data.is_header  = is_hdr;
    q_data.x          = point_x_um;
    q_data.y          = point_y_um;
    q_data.z          = point_z_um;
    q_data.v6         = psh_pkg::sext_id(object_index);
    q_data.v7         = psh_pkg::sext_id(medium_in_index);
    q_data.v8         = psh_pkg::sext_id(medium_out_index);
    q_data.with_media = interaction_kind == transmission_kind;
    if (is_hdr) begin
      q_data.v0   = {62'd0, opcode};
      q_data.v1   = psh_pkg::HashWidth'(count_clip);
      q_data.v2   = psh_pkg::HashWidth'(len_num[psh_pkg::LenWidth:3]);
      q_data.emit = count_clip == '0;
    end else begin
      q_data.v0   = psh_pkg::HashWidth'(interaction_kind);
      q_data.v1   = psh_pkg::sext_id(face_index);
      q_data.v2   = psh_pkg::sext_id(wedge_index);
      q_data.emit = nodes_left <= psh_pkg::CountWidth'(1);
    end
  end

  assign q_push = in_valid && in_ready && (is_hdr || is_node);

  // path tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      path_open  <= 1'b0;
      nodes_left <= '0;
    end else if (q_push) begin
      if (is_hdr) begin
        nodes_left <= count_clip;
        path_open  <= count_clip != '0;
      end else begin
        if (nodes_left != '0) nodes_left <= nodes_left - 1'b1;
        if (nodes_left <= psh_pkg::CountWidth'(1)) path_open <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (path_open && nodes_left == '0) == 1'b0)
    else $error("open path with no nodes left");
  assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst)
    (q_push && is_hdr && count_clip != '0) |=> path_open)
    else $error("header did not open path");

endmodule

@@ sv/psh_queue.sv @@
// two-entry request queue between front and back
module psh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  psh_pkg::work_t wdata,
  input  logic           pop,
  output logic           empty,
  output psh_pkg::work_t rdata
);

  psh_pkg::work_t mem [psh_pkg::QueueDepth];
  logic           wptr;
  logic           rptr;
  logic [1:0]     fill;

  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push && !full) wptr <= !wptr;
      if (pop && !empty) rptr <= !rptr;
      fill <= fill + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfill");
  assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && !empty)) |=> !empty)
    else $error("queue lost request");
  assert property (@(posedge clk) disable iff (rst)
    (wptr == rptr) |-> (fill == 2'd0 || fill == 2'd2))
    else $error("pointer mismatch");

endmodule

@@ sv/psh_div.sv @@
// radix-2 restoring divider for coordinate rounding
module psh_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [psh_pkg::CoordWidth-1:0] coord,
  input  logic [psh_pkg::StepWidth-1:0]         step,
  output logic                                  done,
  output logic [psh_pkg::HashWidth-1:0]         quot
);

  // numerator 2v+s fits 42 bits signed; magnitude 41 bits
  localparam int NW = psh_pkg::CoordWidth + 1;
  localparam int DW = psh_pkg::StepWidth + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]     mag;
  logic [NW-1:0]     q;
  logic [DW:0]       rem;
  logic [DW-1:0]     den;
  logic              neg;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic signed [NW:0] num;
  logic [DW-1:0]     s_eff;
  logic [DW:0]       trial;
  logic [NW:0]       q_adj;

  assign s_eff = (step == '0) ? DW'(1) : {1'b0, step};
  assign num   = (NW+1)'($signed(coord)) * 2 + $signed({1'b0, s_eff});
  assign trial = {rem[DW-1:0], mag[NW-1]} - {1'b0, den};

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        neg  <= num[NW];
        mag  <= num[NW] ? NW'(-num) : NW'(num);
        den  <= {s_eff[DW-2:0], 1'b0};
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        if (!trial[DW]) begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-1:0], mag[NW-1]};
          q   <= {q[NW-2:0], 1'b0};
        end
        mag <= {mag[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // floor for negative numerators
  assign q_adj = neg ? ((rem != '0) ? -({1'b0, q} + 1'b1) : -{1'b0, q}) : {1'b0, q};
  assign quot  = {{(psh_pkg::HashWidth-NW-1){q_adj[NW]}}, q_adj};

endmodule

@@ sv/psh_back.sv @@
// back end: for a node, three rounding divisions, then chained hash combines; a header only combines
module psh_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  psh_pkg::work_t                    q_data,
  input  logic [psh_pkg::StepWidth-1:0]     step,
  output logic                              empty,
  input  logic                              pop,
  output logic [psh_pkg::HashWidth-1:0]     signature
);

  // reciprocal of 125 scaled by 2^33, exact for dividends below 2^26
  localparam logic [26:0] LenRecip = 27'd68719477;

  psh_pkg::back_state_t state;
  psh_pkg::back_state_t state_next;
  psh_pkg::work_t       cur;
  logic [psh_pkg::HashWidth-1:0] hash;
  logic [psh_pkg::HashWidth-1:0] rx;
  logic [psh_pkg::HashWidth-1:0] ry;
  logic [psh_pkg::HashWidth-1:0] rz;
  logic [1:0]  dsel;
  logic [3:0]  mstep;
  logic        div_start;
  logic        div_done;
  logic [psh_pkg::HashWidth-1:0] div_q;
  logic signed [psh_pkg::CoordWidth-1:0] div_in;
  logic [psh_pkg::HashWidth-1:0] mval;
  logic [3:0]  mlast;
  logic        out_full;
  logic [25:0] ld_x;
  logic [52:0] ld_prod;
  logic [18:0] ld_q;
  logic [25:0] ld_r;
  logic [18:0] len_hi;
  logic [18:0] len_lo;
  logic [6:0]  len_rem;

  assign empty = !out_full;

  // divider operand select
  always_comb begin
    case (dsel)
      2'd0:    div_in = cur.x;
      2'd1:    div_in = cur.y;
      default: div_in = cur.z;
    endcase
  end

  psh_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .coord(div_in),
    .step(step), .done(div_done), .quot(div_q)
  );

  // header length over 125, upper then lower 19 bits, during the first two combines
  assign ld_x    = (mstep == 4'd0) ? {7'd0, cur.v2[37:19]} : {len_rem, cur.v2[18:0]};
  assign ld_prod = {27'd0, ld_x} * {26'd0, LenRecip};
  assign ld_q    = ld_prod[51:33];
  assign ld_r    = ld_x - {7'd0, ld_q} * 26'd125;

  // combine operand for each step
  always_comb begin
    case (mstep)
      4'd0:    mval = cur.v0;
      4'd1:    mval = cur.v1;
      4'd2:    mval = cur.is_header ? {26'd0, len_hi, len_lo} : cur.v2;
      4'd3:    mval = rx;
      4'd4:    mval = ry;
      4'd5:    mval = rz;
      4'd6:    mval = cur.v6;
      4'd7:    mval = cur.v7;
      default: mval = cur.v8;
    endcase
  end

  assign mlast = cur.is_header ? 4'd2 : (cur.with_media ? 4'd8 : 4'd6);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psh_pkg::ST_IDLE:
        if (!q_empty) state_next = q_data.is_header ? psh_pkg::ST_MIX : psh_pkg::ST_DIV;
      psh_pkg::ST_DIV:
        if (div_done && dsel == 2'd2) state_next = psh_pkg::ST_MIX;
      psh_pkg::ST_MIX:
        if (mstep == mlast) state_next = cur.emit ? psh_pkg::ST_EMIT : psh_pkg::ST_IDLE;
      psh_pkg::ST_EMIT:
        if (!out_full || pop) state_next = psh_pkg::ST_IDLE;
      default: state_next = psh_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    case (state)
      psh_pkg::ST_IDLE: q_pop = !q_empty;
      psh_pkg::ST_DIV:  div_start = !div_done;
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= psh_pkg::ST_IDLE;
      hash     <= '0;
      dsel     <= '0;
      mstep    <= '0;
    end else begin
      state <= state_next;
      case (state)
        psh_pkg::ST_IDLE: begin
          cur   <= q_data;
          dsel  <= '0;
          mstep <= '0;
          if (!q_empty && q_data.is_header) hash <= '0;
        end
        psh_pkg::ST_DIV:
          if (div_done) begin
            case (dsel)
              2'd0:    rx <= div_q;
              2'd1:    ry <= div_q;
              default: rz <= div_q;
            endcase
            dsel <= dsel + 1'b1;
          end
        psh_pkg::ST_MIX: begin
          hash  <= psh_pkg::mix(hash, mval);
          mstep <= mstep + 1'b1;
          if (cur.is_header && mstep == 4'd0) begin
            len_hi  <= ld_q;
            len_rem <= ld_r[6:0];
          end
          if (cur.is_header && mstep == 4'd1) len_lo <= ld_q;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (state == psh_pkg::ST_EMIT && (!out_full || pop)) begin
      out_full  <= 1'b1;
      signature <= hash;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == psh_pkg::ST_MIX) |-> (mstep <= mlast))
    else $error("combine step overrun");
  assert property (@(posedge clk) disable iff (rst)
    (out_full && !pop) |=> $stable(signature))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == psh_pkg::ST_IDLE)
    else $error("pop outside idle");

endmodule

@@ sv/path_signature_hash_unit.sv @@
// top level of the path signature hash unit
// channel  | handshake      | payload
// input    | push / full    | opcode .. medium_out_index
// result   | pop / empty    | signature
// config   | cfg_we         | cfg_index, cfg_data
// a node passes its three coordinates in turn through the shared radix-2 rounding
// divider, then runs its combines; a header goes straight to its combines.
// the front takes requests while the two-entry queue has room.
// rst is synchronous; registers return to step 1000 and transmission kind 2.
// a waiting result stalls only the back end, the front keeps queueing.
module path_signature_hash_unit #(
  parameter int NODE_LIMIT = psh_pkg::NodeLimitDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            opcode,
  input  logic [psh_pkg::CountWidth-1:0]        node_count,
  input  logic [psh_pkg::LenWidth-1:0]          path_length_um,
  input  logic [psh_pkg::KindWidth-1:0]         interaction_kind,
  input  logic signed [psh_pkg::IdWidth-1:0]    face_index,
  input  logic signed [psh_pkg::IdWidth-1:0]    wedge_index,
  input  logic signed [psh_pkg::CoordWidth-1:0] point_x_um,
  input  logic signed [psh_pkg::CoordWidth-1:0] point_y_um,
  input  logic signed [psh_pkg::CoordWidth-1:0] point_z_um,
  input  logic signed [psh_pkg::IdWidth-1:0]    object_index,
  input  logic signed [psh_pkg::IdWidth-1:0]    medium_in_index,
  input  logic signed [psh_pkg::IdWidth-1:0]    medium_out_index,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [psh_pkg::HashWidth-1:0]         signature,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [psh_pkg::StepWidth-1:0]         cfg_data
);

  logic [psh_pkg::StepWidth-1:0] position_step_um;
  logic [psh_pkg::KindWidth-1:0] transmission_kind;
  logic           in_ready;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  psh_pkg::work_t q_wdata;
  psh_pkg::work_t q_rdata;

  assign full = !in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_step_um  <= psh_pkg::StepReset;
      transmission_kind <= psh_pkg::KindReset;
    end else if (cfg_we) begin
      case (cfg_index)
        psh_pkg::REG_STEP: position_step_um  <= cfg_data;
        psh_pkg::REG_KIND: transmission_kind <= cfg_data[psh_pkg::KindWidth-1:0];
        default: ;
      endcase
    end
  end

  psh_front #(.NODE_LIMIT(NODE_LIMIT)) u_front (
    .clk(clk), .rst(rst), .in_valid(push), .in_ready(in_ready),
    .opcode(opcode), .node_count(node_count), .path_length_um(path_length_um),
    .interaction_kind(interaction_kind), .face_index(face_index),
    .wedge_index(wedge_index), .point_x_um(point_x_um), .point_y_um(point_y_um),
    .point_z_um(point_z_um), .object_index(object_index),
    .medium_in_index(medium_in_index), .medium_out_index(medium_out_index),
    .transmission_kind(transmission_kind),
    .q_push(q_push), .q_full(q_full), .q_data(q_wdata)
  );

  psh_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .full(q_full), .wdata(q_wdata),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  psh_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata),
    .step(position_step_um), .empty(empty), .pop(pop), .signature(signature)
  );

endmodule
